[rtl/grid_ray_march_column_renderer_macros.svh]
// Assertion macros for the checker file of the column renderer.
// Depends on nothing; the files that assert include it by name.
`ifndef GRID_RAY_MARCH_COLUMN_RENDERER_MACROS_SVH
`define GRID_RAY_MARCH_COLUMN_RENDERER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRMCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("grmcr assertion failed");

// Next-cycle implication, checked outside reset.
`define GRMCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("grmcr assertion failed");

`endif

[rtl/grmcr_pkg.sv]
// Shared types and constants of the grid ray march column renderer.
// Used by the front end, the ray queue, the back end and the top level.
package grmcr_pkg;

    // Default geometry.
    localparam int SCREEN_WIDTH_DEF  = 120;
    localparam int SCREEN_HEIGHT_DEF = 40;
    localparam int MAP_SIZE_DEF      = 16;
    localparam int MAX_DEPTH_DEF     = 16;

    // Angle and position scaling.
    localparam int FOV_UNITS      = 8188;
    localparam int HALF_FOV_UNITS = 4094;
    localparam int QUARTER_TURN   = 16384;
    localparam int CELL_SCALE     = 163840;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WALL_0_3   = 3'd0;
    localparam logic [2:0] CFG_WALL_4_7   = 3'd1;
    localparam logic [2:0] CFG_WALL_8_11  = 3'd2;
    localparam logic [2:0] CFG_WALL_12_15 = 3'd3;

    // Cell codes.
    localparam logic [3:0] CODE_BLANK  = 4'd0;
    localparam logic [3:0] CODE_WALL1  = 4'd1;
    localparam logic [3:0] CODE_WALL2  = 4'd2;
    localparam logic [3:0] CODE_WALL3  = 4'd3;
    localparam logic [3:0] CODE_WALL4  = 4'd4;
    localparam logic [3:0] CODE_FLOOR1 = 4'd5;
    localparam logic [3:0] CODE_FLOOR2 = 4'd6;
    localparam logic [3:0] CODE_FLOOR3 = 4'd7;
    localparam logic [3:0] CODE_FLOOR4 = 4'd8;

    // One ray set up by the front end for the back end.
    typedef struct packed {
        logic [15:0]        px;
        logic [15:0]        py;
        logic signed [15:0] sn;
        logic signed [15:0] cs;
    } ray_t;

endpackage

[rtl/grmcr_front.sv]
// Front end: accepts a column item, forms the ray angle and its sine and cosine.
// Depends on grmcr_pkg; pushes one ray_t into the ray queue per item.
module grmcr_front #(
    parameter int SCREEN_WIDTH = grmcr_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_viewer_x,
    input  logic [15:0]         s_viewer_y,
    input  logic [15:0]         s_view_angle,
    input  logic [6:0]          s_column,
    output logic                push,
    output grmcr_pkg::ray_t     push_ray,
    input  logic                q_full
);
    import grmcr_pkg::*;

    // Reciprocal of the screen width, exact for every 20-bit dividend.
    localparam int     RSHIFT = 20 + $clog2(SCREEN_WIDTH);
    localparam longint RECIP  = ((longint'(1) << RSHIFT) + longint'(SCREEN_WIDTH) - 1)
                                / longint'(SCREEN_WIDTH);

    typedef enum logic [3:0] {
        F_IDLE, F_DIV, F_ANG, F_T, F_M1, F_M2, F_M3, F_M4, F_PUSH
    } fstate_t;

    fstate_t            state_reg;
    logic [15:0]        px_reg, py_reg, view_reg, ang_reg;
    logic [19:0]        dvd_reg;
    logic [15:0]        quo_reg;
    logic               phase_reg, neg_reg;
    logic [14:0]        t_reg, t2_reg;
    logic [31:0]        prod_reg;
    logic signed [15:0] sn_reg, cs_reg;

    logic [41:0]        qprod;
    logic [15:0]        a_sel;
    logic [14:0]        t_comb;
    logic [15:0]        u_comb, v_comb, y_comb;

    // Column offset: column*FOV over the screen width by a reciprocal multiply.
    assign qprod = 42'(dvd_reg) * 42'(RECIP);

    // Quarter-wave fold of the angle.
    assign a_sel  = phase_reg ? (ang_reg + 16'(QUARTER_TURN)) : ang_reg;
    assign t_comb = a_sel[14] ? (15'(QUARTER_TURN) - {1'b0, a_sel[13:0]})
                              : {1'b0, a_sel[13:0]};
    assign u_comb = 16'd10512 - prod_reg[29:14];
    assign v_comb = 16'd25736 - prod_reg[29:14];
    assign y_comb = prod_reg[29:14];

    assign s_ready  = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_full;
    assign push_ray = '{px: px_reg, py: py_reg, sn: sn_reg, cs: cs_reg};

    // Sequencer: column offset, angle, then sine and cosine over a shared multiplier.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        px_reg    <= s_viewer_x;
                        py_reg    <= s_viewer_y;
                        view_reg  <= s_view_angle;
                        dvd_reg   <= 20'(s_column * 20'(FOV_UNITS));
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    quo_reg   <= 16'(qprod >> RSHIFT);
                    state_reg <= F_ANG;
                end
                F_ANG: begin
                    ang_reg   <= view_reg - 16'(HALF_FOV_UNITS) + quo_reg;
                    phase_reg <= 1'b0;
                    state_reg <= F_T;
                end
                F_T: begin
                    t_reg     <= t_comb;
                    neg_reg   <= a_sel[15];
                    prod_reg  <= 32'(t_comb) * 32'(t_comb);
                    state_reg <= F_M1;
                end
                F_M1: begin
                    t2_reg    <= prod_reg[28:14];
                    prod_reg  <= 32'(prod_reg[28:14]) * 32'd1160;
                    state_reg <= F_M2;
                end
                F_M2: begin
                    prod_reg  <= 32'(t2_reg) * 32'(u_comb);
                    state_reg <= F_M3;
                end
                F_M3: begin
                    prod_reg  <= 32'(t_reg) * 32'(v_comb);
                    state_reg <= F_M4;
                end
                F_M4: begin
                    if (!phase_reg) begin
                        sn_reg    <= neg_reg ? -$signed(y_comb) : $signed(y_comb);
                        phase_reg <= 1'b1;
                        state_reg <= F_T;
                    end else begin
                        cs_reg    <= neg_reg ? -$signed(y_comb) : $signed(y_comb);
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

[rtl/grmcr_queue.sv]
// Two-entry ray queue between the front end and the back end.
// Depends on grmcr_pkg for the ray_t entry type.
module grmcr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  grmcr_pkg::ray_t push_ray,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output grmcr_pkg::ray_t head
);
    import grmcr_pkg::*;

    ray_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = mem_reg[rptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_ray;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/grmcr_back.sv]
// Back end: marches a ray over the wall map, sizes the wall, emits the rows.
// Depends on grmcr_pkg; takes rays from the ray queue.
module grmcr_back #(
    parameter int SCREEN_HEIGHT = grmcr_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAP_SIZE      = grmcr_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH     = grmcr_pkg::MAX_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [255:0]    wall_map,
    input  logic            q_nonempty,
    input  grmcr_pkg::ray_t q_head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [5:0]      m_row,
    output logic [3:0]      m_cell_code,
    output logic            m_last
);
    import grmcr_pkg::*;

    localparam int MAX_STEPS = MAX_DEPTH * 10;
    localparam int KW        = $clog2(MAX_STEPS + 1);
    localparam int D10       = 10 * MAX_DEPTH;
    localparam int LIMIT     = MAP_SIZE * CELL_SCALE;

    typedef enum logic [2:0] {B_IDLE, B_MARCH, B_SIZE, B_DIV, B_EMIT} bstate_t;

    bstate_t            state_reg;
    logic signed [25:0] nx_reg, ny_reg;
    logic signed [15:0] sn_reg, cs_reg;
    logic [KW-1:0]      k_reg, dist_reg;
    logic               hit_reg, neg_reg;
    logic [15:0]        dvd_reg, quo_reg;
    logic [11:0]        den_reg, rem_reg;
    logic [3:0]         cnt_reg;
    logic [3:0]         wcode_reg;
    logic [5:0]         y_reg;
    logic               m_valid_reg, m_last_reg;
    logic [5:0]         m_row_reg;
    logic [3:0]         m_code_reg;

    logic        out_map;
    logic [15:0] cx_prod, cy_prod;
    logic [3:0]  cx, cy;
    logic        is_wall;
    logic [11:0] d12;
    logic [3:0]  shade;
    logic signed [17:0] num;
    logic [11:0] rem_try;
    logic signed [17:0] ceil_comb, floor_row, ys;
    logic [9:0]  mrow;
    logic [3:0]  code_comb;
    logic        load;

    // Cell lookup: nx/163840 is (nx>>15)/5, done by a reciprocal multiply.
    assign out_map = nx_reg[25] || ny_reg[25] || (nx_reg >= 26'(LIMIT)) ||
                     (ny_reg >= 26'(LIMIT));
    assign cx_prod = 16'(nx_reg[22:15]) * 16'd205;
    assign cy_prod = 16'(ny_reg[22:15]) * 16'd205;
    assign cx      = cx_prod[13:10];
    assign cy      = cy_prod[13:10];
    assign is_wall = wall_map[{cy, cx}];

    // Wall shade from the stopping distance.
    assign d12 = 12'(dist_reg);
    always_comb begin
        priority if ((d12 << 2) <= 12'(D10)) shade = CODE_WALL1;
        else if ((d12 * 12'd3) <= 12'(D10)) shade = CODE_WALL2;
        else if ((d12 << 1) <= 12'(D10))    shade = CODE_WALL3;
        else                                shade = CODE_WALL4;
    end

    // Numerator of the ceiling height, and one division step of its magnitude.
    // The quotient and its sign hold still while the rows are emitted.
    assign num     = $signed(18'(SCREEN_HEIGHT) * 18'(dist_reg)) -
                     $signed(18'(20 * SCREEN_HEIGHT));
    assign rem_try = {rem_reg[10:0], dvd_reg[15]};
    assign ceil_comb = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});

    // Cell code of the current row.
    assign floor_row = 18'(SCREEN_HEIGHT) - ceil_comb;
    assign ys        = $signed({12'b0, y_reg});
    assign mrow      = 10'(SCREEN_HEIGHT) - 10'(y_reg);
    always_comb begin
        priority if (ys < ceil_comb)                    code_comb = CODE_BLANK;
        else if (ys <= floor_row)                       code_comb = wcode_reg;
        else if ((mrow << 3) < 10'(SCREEN_HEIGHT))      code_comb = CODE_FLOOR1;
        else if ((mrow << 2) < 10'(SCREEN_HEIGHT))      code_comb = CODE_FLOOR2;
        else if ((mrow << 3) < 10'(3 * SCREEN_HEIGHT))  code_comb = CODE_FLOOR3;
        else                                            code_comb = CODE_FLOOR4;
    end

    assign pop  = (state_reg == B_IDLE) && q_nonempty;
    assign load = (state_reg == B_EMIT) && (!m_valid_reg || m_ready);

    assign m_valid     = m_valid_reg;
    assign m_row       = m_row_reg;
    assign m_cell_code = m_code_reg;
    assign m_last      = m_last_reg;

    // Sequencer: march one step a cycle, divide, then emit one row per transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Output register: filled by a row load, emptied by a transfer.
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (q_nonempty) begin
                        nx_reg    <= 26'({q_head.px, 5'b0}) + 26'({q_head.px, 3'b0})
                                     + 26'(q_head.sn);
                        ny_reg    <= 26'({q_head.py, 5'b0}) + 26'({q_head.py, 3'b0})
                                     + 26'(q_head.cs);
                        sn_reg    <= q_head.sn;
                        cs_reg    <= q_head.cs;
                        k_reg     <= KW'(1);
                        state_reg <= B_MARCH;
                    end
                end
                B_MARCH: begin
                    if (out_map || is_wall || (k_reg == KW'(MAX_STEPS))) begin
                        dist_reg  <= (is_wall && !out_map) ? k_reg : KW'(MAX_STEPS);
                        hit_reg   <= out_map || is_wall;
                        state_reg <= B_SIZE;
                    end else begin
                        k_reg  <= k_reg + KW'(1);
                        nx_reg <= nx_reg + 26'(sn_reg);
                        ny_reg <= ny_reg + 26'(cs_reg);
                    end
                end
                B_SIZE: begin
                    neg_reg   <= num[17];
                    dvd_reg   <= num[17] ? 16'(-num) : 16'(num);
                    den_reg   <= 12'(2 * dist_reg);
                    wcode_reg <= hit_reg ? shade : CODE_BLANK;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    dvd_reg <= {dvd_reg[14:0], 1'b0};
                    if (rem_try >= den_reg) begin
                        rem_reg <= rem_try - den_reg;
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end else begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= B_EMIT;
                        y_reg     <= '0;
                    end
                end
                B_EMIT: begin
                    if (load) begin
                        m_row_reg   <= y_reg;
                        m_code_reg  <= code_comb;
                        m_last_reg  <= (y_reg == 6'(SCREEN_HEIGHT - 1));
                        y_reg       <= y_reg + 6'd1;
                        if (y_reg == 6'(SCREEN_HEIGHT - 1)) begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

[rtl/grid_ray_march_column_renderer.sv]
// Top level of the grid ray march column renderer: wall map registers and the
// front end, ray queue and back end. Depends on grmcr_pkg and the grmcr_* modules.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    viewer_x, viewer_y, view_angle, column
//   m_        out        m_valid/m_ready    row, cell_code, last (40 per column)
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// After a transfer the front end does one reciprocal multiply, the angle, two sine
// evaluations on one multiplier and a push that waits while the ray queue is full;
// it takes no new item until it is idle again, and it overlaps with the back end.
// The back end pops a ray, marches it to a wall, the map edge or the depth limit,
// sizes the wall by a serial division, then emits one row per transfer.
// Reset clears the wall map and all control state; a stalled m_ready holds the
// current row, and the two-entry ray queue lets the front end keep working.
module grid_ray_march_column_renderer #(
    parameter int SCREEN_WIDTH  = grmcr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grmcr_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAP_SIZE      = grmcr_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH     = grmcr_pkg::MAX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_viewer_x,
    input  logic [15:0] s_viewer_y,
    input  logic [15:0] s_view_angle,
    input  logic [6:0]  s_column,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_row,
    output logic [3:0]  m_cell_code,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import grmcr_pkg::*;

    logic [63:0] wall_reg [4];
    logic        push, q_full, pop, q_nonempty;
    ray_t        push_ray, q_head;

    // Wall map registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_reg[0] <= '0;
            wall_reg[1] <= '0;
            wall_reg[2] <= '0;
            wall_reg[3] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WALL_0_3:   wall_reg[0] <= cfg_wdata;
                CFG_WALL_4_7:   wall_reg[1] <= cfg_wdata;
                CFG_WALL_8_11:  wall_reg[2] <= cfg_wdata;
                CFG_WALL_12_15: wall_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    grmcr_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_viewer_x, .s_viewer_y,
        .s_view_angle, .s_column, .push, .push_ray, .q_full
    );

    grmcr_queue u_queue (
        .aclk, .aresetn, .push, .push_ray, .full(q_full), .pop,
        .nonempty(q_nonempty), .head(q_head)
    );

    grmcr_back #(
        .SCREEN_HEIGHT(SCREEN_HEIGHT), .MAP_SIZE(MAP_SIZE), .MAX_DEPTH(MAX_DEPTH)
    ) u_back (
        .aclk, .aresetn,
        .wall_map({wall_reg[3], wall_reg[2], wall_reg[1], wall_reg[0]}),
        .q_nonempty, .q_head, .pop, .m_valid, .m_ready, .m_row, .m_cell_code, .m_last
    );

endmodule

[rtl/grmcr_checker.sv]
// Port checker of the column renderer's result channel, bound to the top level.
// Depends on grid_ray_march_column_renderer_macros.svh.
`include "grid_ray_march_column_renderer_macros.svh"

module grmcr_checker #(
    parameter int SCREEN_HEIGHT = grmcr_pkg::SCREEN_HEIGHT_DEF
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_row,
    input logic [3:0] m_cell_code,
    input logic       m_last
);

    // The final cell of a column sits on the bottom row.
    `GRMCR_ASSERT_IMPL(a_last_row, aclk, aresetn, m_valid && m_last, m_row == 6'(SCREEN_HEIGHT - 1))

    // Only defined cell codes are shown.
    `GRMCR_ASSERT_IMPL(a_code_range, aclk, aresetn, m_valid, m_cell_code <= 4'd8)

    // Within a column, the next row follows right after each transfer.
    `GRMCR_ASSERT_NEXT(a_row_step, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && (m_row == $past(m_row) + 6'd1))

    // A stalled result holds its row.
    `GRMCR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_row))

endmodule

bind grid_ray_march_column_renderer grmcr_checker #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_chk (.*);
